### design/gtq_pkg.sv
// gtq_pkg: constants, types and state codes for the grouped team queue
// no dependencies; imported by grouped_team_queue_unit and gtq_port_checks
package gtq_pkg;

    localparam int TEAM_COUNT    = 1024;
    localparam int ELEMENT_COUNT = 65536;
    localparam int NODE_COUNT    = 4096;

    localparam int TEAM_W  = $clog2(TEAM_COUNT);
    localparam int ELEM_W  = 16;
    localparam int ELEM_AW = $clog2(ELEMENT_COUNT);
    localparam int NODE_W  = $clog2(NODE_COUNT);
    localparam int NCNT_W  = NODE_W + 1;
    localparam int OCNT_W  = TEAM_W + 1;

    typedef enum logic [1:0] {
        ACT_ASSIGN  = 2'd0,
        ACT_ENQUEUE = 2'd1,
        ACT_DEQUEUE = 2'd2,
        ACT_CLEAR   = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ASSIGN,
        ST_ENQ_RD,
        ST_ENQ_TEAM,
        ST_ENQ_WR,
        ST_DEQ_RD,
        ST_DEQ_TEAM,
        ST_DEQ_NODE,
        ST_DEQ_WR
    } state_t;

    // per-team record: active flag, first and last node of the team queue
    typedef struct packed {
        logic              active;
        logic [NODE_W-1:0] head;
        logic [NODE_W-1:0] tail;
    } team_entry_t;

    localparam int TEAM_ENTRY_W = $bits(team_entry_t);

endpackage

### design/gtq_ram.sv
// gtq_ram: simple dual-port synchronous ram, one write and one registered read
// no dependencies
module gtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/grouped_team_queue_unit.sv
// grouped_team_queue_unit: team queue sequencer over membership, team, order
// and node memories; depends on gtq_pkg and gtq_ram
//
// usage:
//   a command transaction is taken at a clock edge where start is high and
//   busy is low; action selects assign, enqueue, dequeue or clear, with
//   element and team as operands. busy stays high until the command is done.
//   a successful dequeue shows served_element with result_valid high for
//   exactly one cycle; the receiver cannot stall it.
//   the unit returns to idle between commands. the dequeue result is on
//   the ports in its write-back state. enqueue is a chain of dependent
//   memory reads (membership, then team record) followed by a write-back
//   state; dequeue reads order, then team record, then node, and then
//   writes back. clear and reset run a sweep over the 65536-entry
//   membership memory, one entry a cycle, clearing team active flags on
//   the way; busy is high for the whole sweep after reset is released.
//   an enqueue with no free node is dropped; a dequeue on an empty queue
//   gives no result.
module grouped_team_queue_unit
    import gtq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        action,
    input  logic [ELEM_W-1:0] element,
    input  logic [TEAM_W-1:0] team,
    output logic              result_valid,
    output logic [ELEM_W-1:0] served_element
);

    state_t state_reg, state_next;

    logic [ELEM_W-1:0]  elem_reg;
    logic [TEAM_W-1:0]  team_reg;
    logic [ELEM_AW-1:0] sweep_reg;
    logic [NODE_W-1:0]  free_head_reg;
    logic [NCNT_W-1:0]  fresh_reg;
    logic [NCNT_W-1:0]  free_cnt_reg;
    logic [TEAM_W-1:0]  order_head_reg;
    logic [TEAM_W-1:0]  order_tail_reg;
    logic [OCNT_W-1:0]  order_cnt_reg;

    // memory ports
    logic               mb_we, mb_re;
    logic [ELEM_AW-1:0] mb_waddr, mb_raddr;
    logic [TEAM_W-1:0]  mb_wdata, mb_rdata;
    logic               tm_we, tm_re;
    logic [TEAM_W-1:0]  tm_waddr, tm_raddr;
    team_entry_t        tm_wdata, tm_rdata;
    logic               od_we, od_re;
    logic [TEAM_W-1:0]  od_waddr, od_raddr, od_wdata, od_rdata;
    logic               nv_we, nv_re;
    logic [NODE_W-1:0]  nv_waddr, nv_raddr;
    logic [ELEM_W-1:0]  nv_wdata, nv_rdata;
    logic               nn_we, nn_re;
    logic [NODE_W-1:0]  nn_waddr, nn_raddr, nn_wdata, nn_rdata;

    logic              can_alloc;
    logic              fresh_pop;
    logic [NODE_W-1:0] free_after_pop;
    logic              deq_last;
    logic              sweep_done;

    gtq_ram #(.WIDTH(TEAM_W), .DEPTH(ELEMENT_COUNT)) u_member (
        .clk(clk), .we(mb_we), .waddr(mb_waddr), .wdata(mb_wdata),
        .re(mb_re), .raddr(mb_raddr), .rdata(mb_rdata)
    );

    gtq_ram #(.WIDTH(TEAM_ENTRY_W), .DEPTH(TEAM_COUNT)) u_team (
        .clk(clk), .we(tm_we), .waddr(tm_waddr), .wdata(tm_wdata),
        .re(tm_re), .raddr(tm_raddr), .rdata(tm_rdata)
    );

    gtq_ram #(.WIDTH(TEAM_W), .DEPTH(TEAM_COUNT)) u_order (
        .clk(clk), .we(od_we), .waddr(od_waddr), .wdata(od_wdata),
        .re(od_re), .raddr(od_raddr), .rdata(od_rdata)
    );

    gtq_ram #(.WIDTH(ELEM_W), .DEPTH(NODE_COUNT)) u_value (
        .clk(clk), .we(nv_we), .waddr(nv_waddr), .wdata(nv_wdata),
        .re(nv_re), .raddr(nv_raddr), .rdata(nv_rdata)
    );

    gtq_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_next (
        .clk(clk), .we(nn_we), .waddr(nn_waddr), .wdata(nn_wdata),
        .re(nn_re), .raddr(nn_raddr), .rdata(nn_rdata)
    );

    // free list: recycled nodes first, then never-used nodes in order
    assign can_alloc      = (free_cnt_reg != '0);
    assign fresh_pop      = (fresh_reg < NCNT_W'(NODE_COUNT))
                            && (free_head_reg == fresh_reg[NODE_W-1:0]);
    assign free_after_pop = fresh_pop ? free_head_reg + NODE_W'(1) : nn_rdata;
    assign deq_last       = (tm_rdata.head == tm_rdata.tail);
    assign sweep_done     = (sweep_reg == {ELEM_AW{1'b1}});

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (action)
                        ACT_ASSIGN:  state_next = ST_ASSIGN;
                        ACT_ENQUEUE: state_next = ST_ENQ_RD;
                        ACT_DEQUEUE: state_next = ST_DEQ_RD;
                        ACT_CLEAR:   state_next = ST_CLEAR;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR:    state_next = sweep_done ? ST_IDLE : ST_CLEAR;
            ST_ASSIGN:   state_next = ST_IDLE;
            ST_ENQ_RD:   state_next = ST_ENQ_TEAM;
            ST_ENQ_TEAM: state_next = ST_ENQ_WR;
            ST_ENQ_WR:   state_next = ST_IDLE;
            ST_DEQ_RD:   state_next = (order_cnt_reg == '0) ? ST_IDLE : ST_DEQ_TEAM;
            ST_DEQ_TEAM: state_next = ST_DEQ_NODE;
            ST_DEQ_NODE: state_next = ST_DEQ_WR;
            ST_DEQ_WR:   state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // memory controls and outputs
    always_comb
    begin
        mb_we = 1'b0; mb_waddr = elem_reg;    mb_wdata = team_reg;
        mb_re = 1'b0; mb_raddr = elem_reg;
        tm_we = 1'b0; tm_waddr = mb_rdata;    tm_wdata = '0;
        tm_re = 1'b0; tm_raddr = mb_rdata;
        od_we = 1'b0; od_waddr = order_tail_reg; od_wdata = mb_rdata;
        od_re = 1'b0; od_raddr = order_head_reg;
        nv_we = 1'b0; nv_waddr = free_head_reg;  nv_wdata = elem_reg;
        nv_re = 1'b0; nv_raddr = tm_rdata.head;
        nn_we = 1'b0; nn_waddr = tm_rdata.tail;  nn_wdata = free_head_reg;
        nn_re = 1'b0; nn_raddr = free_head_reg;
        busy         = (state_reg != ST_IDLE);
        result_valid = 1'b0;
        served_element = nv_rdata;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mb_we    = 1'b1;
                mb_waddr = sweep_reg;
                mb_wdata = '0;
                tm_we    = (sweep_reg < ELEM_AW'(TEAM_COUNT));
                tm_waddr = sweep_reg[TEAM_W-1:0];
                tm_wdata = '0;
            end
            ST_ASSIGN:
            begin
                mb_we = 1'b1;
            end
            ST_ENQ_RD:
            begin
                mb_re = 1'b1;
                nn_re = 1'b1;
            end
            ST_ENQ_TEAM:
            begin
                tm_re = 1'b1;
            end
            ST_ENQ_WR:
            begin
                if (can_alloc)
                begin
                    nv_we = 1'b1;
                    tm_we = 1'b1;
                    if (tm_rdata.active)
                    begin
                        nn_we    = 1'b1;
                        nn_waddr = tm_rdata.tail;
                        nn_wdata = free_head_reg;
                        tm_wdata = '{active: 1'b1, head: tm_rdata.head, tail: free_head_reg};
                    end
                    else
                    begin
                        od_we    = 1'b1;
                        tm_wdata = '{active: 1'b1, head: free_head_reg, tail: free_head_reg};
                    end
                end
            end
            ST_DEQ_RD:
            begin
                od_re = (order_cnt_reg != '0);
            end
            ST_DEQ_TEAM:
            begin
                tm_re    = 1'b1;
                tm_raddr = od_rdata;
            end
            ST_DEQ_NODE:
            begin
                nv_re    = 1'b1;
                nn_re    = 1'b1;
                nn_raddr = tm_rdata.head;
            end
            ST_DEQ_WR:
            begin
                result_valid = 1'b1;
                tm_we    = 1'b1;
                tm_waddr = od_rdata;
                tm_wdata = deq_last
                    ? '{active: 1'b0, head: tm_rdata.head, tail: tm_rdata.tail}
                    : '{active: 1'b1, head: nn_rdata, tail: tm_rdata.tail};
                nn_we    = 1'b1;
                nn_waddr = tm_rdata.head;
                nn_wdata = free_head_reg;
            end
            default:
            begin
                busy = (state_reg != ST_IDLE);
            end
        endcase
    end

    // command capture, sweep and queue bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            sweep_reg      <= '0;
            free_head_reg  <= '0;
            fresh_reg      <= '0;
            free_cnt_reg   <= NCNT_W'(NODE_COUNT);
            order_head_reg <= '0;
            order_tail_reg <= '0;
            order_cnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start && action == ACT_CLEAR)
                    begin
                        sweep_reg      <= '0;
                        free_head_reg  <= '0;
                        fresh_reg      <= '0;
                        free_cnt_reg   <= NCNT_W'(NODE_COUNT);
                        order_head_reg <= '0;
                        order_tail_reg <= '0;
                        order_cnt_reg  <= '0;
                    end
                end
                ST_CLEAR:
                begin
                    sweep_reg <= sweep_reg + ELEM_AW'(1);
                end
                ST_ENQ_WR:
                begin
                    if (can_alloc)
                    begin
                        free_head_reg <= free_after_pop;
                        free_cnt_reg  <= free_cnt_reg - NCNT_W'(1);
                        if (fresh_pop)
                        begin
                            fresh_reg <= fresh_reg + NCNT_W'(1);
                        end
                        if (!tm_rdata.active)
                        begin
                            order_tail_reg <= order_tail_reg + TEAM_W'(1);
                            order_cnt_reg  <= order_cnt_reg + OCNT_W'(1);
                        end
                    end
                end
                ST_DEQ_WR:
                begin
                    free_head_reg <= tm_rdata.head;
                    free_cnt_reg  <= free_cnt_reg + NCNT_W'(1);
                    if (deq_last)
                    begin
                        order_head_reg <= order_head_reg + TEAM_W'(1);
                        order_cnt_reg  <= order_cnt_reg - OCNT_W'(1);
                    end
                end
                default:
                begin
                    sweep_reg <= sweep_reg;
                end
            endcase
        end
    end

    // operand capture
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            elem_reg <= element;
            team_reg <= team;
        end
    end

endmodule

### design/gtq_checker.sv
// gtq_port_checks: port-level checks on the grouped team queue unit
// depends on gtq_pkg; bound to grouped_team_queue_unit
module gtq_port_checks
    import gtq_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic [1:0]        action,
    input logic              result_valid
);

    // a result only shows while a command is in flight
    assert property (@(posedge clk) disable iff (!rst_n) result_valid |-> busy)
        else $error("result strobe while idle");

    // a result strobe lasts one cycle
    assert property (@(posedge clk) disable iff (!rst_n) result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    // an accepted command keeps the unit busy and gives no result at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !result_valid))
        else $error("accepted transaction not tracked");

    // only a dequeue makes a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action != ACT_DEQUEUE) |=> ##3 !result_valid)
        else $error("result from a non-dequeue transaction");

endmodule

bind grouped_team_queue_unit gtq_port_checks u_gtq_port_checks (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .action(action),
    .result_valid(result_valid)
);
